[hdl/mhts_pkg.sv]
// Package for the music header tag scanner: widths, tag codes, rate sources
// and the tag hit struct. No dependencies.
package mhts_pkg;

	localparam int POS_W     = 12;
	localparam int OFF_W     = 11;
	localparam int ACC_W     = 16;
	localparam int SRC_W     = 3;
	localparam int NUM_LONG  = 5;
	localparam int NUM_SHORT = 5;

	localparam int DEFAULT_SCAN_WINDOW = 1024;

	localparam logic [POS_W-1:0] POS_MAX      = '1;
	localparam logic [ACC_W-1:0] DEFAULT_RATE = 16'd50;
	localparam logic [7:0]       DIGIT_BASE   = 8'h30;

	// long tag indexes: SNDH, then the four metadata tags
	localparam int LT_SNDH = 0;

	localparam logic [31:0] LONG_TAGS [NUM_LONG] = '{
		32'h534E4448, // SNDH
		32'h5449544C, // TITL
		32'h434F4D4D, // COMM
		32'h52495050, // RIPP
		32'h434F4E56  // CONV
	};

	localparam logic [15:0] SHORT_TAGS [NUM_SHORT] = '{
		16'h5443, // TC
		16'h5441, // TA
		16'h5442, // TB
		16'h5444, // TD
		16'h5621  // V!
	};

	localparam logic [SRC_W-1:0] SRC_DEFAULT = 3'd5;

	typedef struct packed {
		logic [NUM_LONG-1:0]  long_hit;
		logic [NUM_SHORT-1:0] short_hit;
	} tag_hit_t;

endpackage

[hdl/mhts_byte_if.sv]
// Byte request channel for the music header tag scanner.
// Depends on nothing.
interface mhts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       last_byte;

	modport source (output valid, file_byte, last_byte, input ready);
	modport sink   (input valid, file_byte, last_byte, output ready);
endinterface

[hdl/mhts_result_if.sv]
// Result request channel for the music header tag scanner.
// Depends on nothing.
interface mhts_result_if;
	logic        valid;
	logic        ready;
	logic        header_valid;
	logic        title_found;
	logic [10:0] title_offset;
	logic        composer_found;
	logic [10:0] composer_offset;
	logic        ripper_found;
	logic [10:0] ripper_offset;
	logic        converter_found;
	logic [10:0] converter_offset;
	logic [15:0] replay_rate;
	logic [2:0]  rate_source;

	modport source (output valid, header_valid, title_found, title_offset,
		composer_found, composer_offset, ripper_found, ripper_offset,
		converter_found, converter_offset, replay_rate, rate_source,
		input ready);
	modport sink   (input valid, header_valid, title_found, title_offset,
		composer_found, composer_offset, ripper_found, ripper_offset,
		converter_found, converter_offset, replay_rate, rate_source,
		output ready);
endinterface

[hdl/mhts_tag_match.sv]
// Parallel tag compare for one byte against the recent-byte window.
// Depends on mhts_pkg.
module mhts_tag_match
	import mhts_pkg::*;
#(
	parameter int SCAN_WINDOW = DEFAULT_SCAN_WINDOW
) (
	input  logic [23:0]          recent,
	input  logic [7:0]           data,
	input  logic [POS_W-1:0]     pos,
	input  logic [NUM_LONG-1:0]  long_seen,
	input  logic [NUM_SHORT-1:0] short_seen,
	output tag_hit_t             hits
);

	// a tag may match while its first byte lies below the window
	localparam logic [POS_W-1:0] LONG_LIM  = POS_W'(SCAN_WINDOW + 3);
	localparam logic [POS_W-1:0] SHORT_LIM = POS_W'(SCAN_WINDOW + 1);

	logic [31:0] w4;
	logic [15:0] w2;
	logic        long_ok;
	logic        short_ok;

	assign w4       = {recent, data};
	assign w2       = {recent[7:0], data};
	assign long_ok  = (pos >= POS_W'(3)) && (pos < LONG_LIM);
	assign short_ok = (pos >= POS_W'(1)) && (pos < SHORT_LIM);

	always_comb begin
		for (int k = 0; k < NUM_LONG; k++) begin
			hits.long_hit[k] = long_ok && !long_seen[k] && (w4 == LONG_TAGS[k]);
		end
		for (int k = 0; k < NUM_SHORT; k++) begin
			hits.short_hit[k] = short_ok && !short_seen[k] && (w2 == SHORT_TAGS[k]);
		end
	end

endmodule

[hdl/mhts_dec_acc.sv]
// One decimal accumulator: value*10 + byte - '0', stops at a zero byte.
// Depends on mhts_pkg.
module mhts_dec_acc
	import mhts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             clear,
	input  logic [7:0]       data,
	input  logic             start,
	output logic [ACC_W-1:0] acc_nxt
);

	logic [ACC_W-1:0] acc_q;
	logic             running_q;
	logic             running_nxt;
	logic [ACC_W-1:0] acc_x10;

	assign acc_x10 = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0};

	always_comb begin
		acc_nxt     = acc_q;
		running_nxt = running_q;
		if (running_q) begin
			if (data == 8'h00) begin
				running_nxt = 1'b0;
			end else begin
				acc_nxt = acc_x10 + ACC_W'(data) - ACC_W'(DIGIT_BASE);
			end
		end
		// the byte that completes the tag is not fed to its own accumulator
		if (start) begin
			running_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			running_q <= 1'b0;
		end else if (step) begin
			if (clear) begin
				acc_q     <= '0;
				running_q <= 1'b0;
			end else begin
				acc_q     <= acc_nxt;
				running_q <= running_nxt;
			end
		end
	end

endmodule

[hdl/music_header_tag_scanner_top.sv]
// Music header tag scanner: input register, scan state, result register.
// Depends on mhts_pkg, mhts_byte_if, mhts_result_if, mhts_tag_match, mhts_dec_acc.
//
// Usage:
//  bytes  : header bytes from offset 0, one request per byte; last_byte marks
//           the final byte of a file.
//  result : one request per file, issued for the byte marked last.
//  Throughput is one byte per cycle while bytes.ready is high. A byte is held
//  in the input register, then updates the scan state; the result register
//  loads as the last byte leaves the input register, so a result passes
//  through the input register and then the result register before it is valid.
//  The tag compares and the five accumulators (shift-add by ten) all work
//  within the one stage between the input register and the scan state.
//  Scan state clears itself when a result is formed, so the next file may
//  follow with no gap. Reset clears the scan state and the valid flags of
//  the input register and the result register.
//  When the receiver stalls, bytes of the next file keep flowing; only a
//  second last byte waiting for a full result register holds bytes.ready low.
module music_header_tag_scanner_top
	import mhts_pkg::*;
#(
	parameter int SCAN_WINDOW = DEFAULT_SCAN_WINDOW
) (
	input  logic          clk,
	input  logic          arst_n,
	mhts_byte_if.sink     bytes,
	mhts_result_if.source result
);

	// input register
	logic       vld_s1;
	logic       last_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// scan state
	logic [23:0]          recent_q;
	logic [POS_W-1:0]     pos_q;
	logic [NUM_LONG-1:0]  long_seen_q;
	logic [OFF_W-1:0]     long_off_q [1:NUM_LONG-1];
	logic [NUM_SHORT-1:0] short_seen_q;

	// result register
	logic             out_vld_q;
	logic             hv_q;
	logic [NUM_LONG-1:1] found_q;
	logic [OFF_W-1:0] off_res_q [1:NUM_LONG-1];
	logic [ACC_W-1:0] rate_q;
	logic [SRC_W-1:0] src_q;

	tag_hit_t             hits;
	logic [ACC_W-1:0]     acc_nxt [NUM_SHORT];
	logic [NUM_LONG-1:0]  long_seen_nxt;
	logic [NUM_SHORT-1:0] short_seen_nxt;
	logic [OFF_W-1:0]     off_nxt [1:NUM_LONG-1];
	logic [OFF_W-1:0]     off_here;
	logic [POS_W-1:0]     pos_nxt;
	logic [ACC_W-1:0]     rate_sel;
	logic [SRC_W-1:0]     src_sel;

	assign advance     = vld_s1 && !(last_s1 && out_vld_q && !result.ready);
	assign bytes.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (bytes.ready) begin
			vld_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.file_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	mhts_tag_match #(
		.SCAN_WINDOW(SCAN_WINDOW)
	) u_match (
		.recent     (recent_q),
		.data       (byte_s1),
		.pos        (pos_q),
		.long_seen  (long_seen_q),
		.short_seen (short_seen_q),
		.hits       (hits)
	);

	for (genvar k = 0; k < NUM_SHORT; k++) begin : g_acc
		mhts_dec_acc u_acc (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (advance),
			.clear   (last_s1),
			.data    (byte_s1),
			.start   (hits.short_hit[k]),
			.acc_nxt (acc_nxt[k])
		);
	end

	assign long_seen_nxt  = long_seen_q | hits.long_hit;
	assign short_seen_nxt = short_seen_q | hits.short_hit;
	assign off_here       = OFF_W'(pos_q + POS_W'(1));
	assign pos_nxt        = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

	always_comb begin
		for (int k = 1; k < NUM_LONG; k++) begin
			off_nxt[k] = hits.long_hit[k] ? off_here : long_off_q[k];
		end
	end

	// first found short tag in priority order wins
	always_comb begin
		rate_sel = DEFAULT_RATE;
		src_sel  = SRC_DEFAULT;
		for (int k = NUM_SHORT - 1; k >= 0; k--) begin
			if (short_seen_nxt[k]) begin
				rate_sel = acc_nxt[k];
				src_sel  = SRC_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q     <= '0;
			pos_q        <= '0;
			long_seen_q  <= '0;
			short_seen_q <= '0;
			for (int k = 1; k < NUM_LONG; k++) begin
				long_off_q[k] <= '0;
			end
		end else if (advance) begin
			if (last_s1) begin
				recent_q     <= '0;
				pos_q        <= '0;
				long_seen_q  <= '0;
				short_seen_q <= '0;
				for (int k = 1; k < NUM_LONG; k++) begin
					long_off_q[k] <= '0;
				end
			end else begin
				recent_q     <= {recent_q[15:0], byte_s1};
				pos_q        <= pos_nxt;
				long_seen_q  <= long_seen_nxt;
				short_seen_q <= short_seen_nxt;
				for (int k = 1; k < NUM_LONG; k++) begin
					long_off_q[k] <= off_nxt[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// no header: every field reads zero
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			hv_q <= long_seen_nxt[LT_SNDH];
			for (int k = 1; k < NUM_LONG; k++) begin
				found_q[k]   <= long_seen_nxt[LT_SNDH] && long_seen_nxt[k];
				off_res_q[k] <= (long_seen_nxt[LT_SNDH] && long_seen_nxt[k]) ?
					off_nxt[k] : '0;
			end
			rate_q <= long_seen_nxt[LT_SNDH] ? rate_sel : '0;
			src_q  <= long_seen_nxt[LT_SNDH] ? src_sel : '0;
		end
	end

	assign result.valid            = out_vld_q;
	assign result.header_valid     = hv_q;
	assign result.title_found      = found_q[1];
	assign result.title_offset     = off_res_q[1];
	assign result.composer_found   = found_q[2];
	assign result.composer_offset  = off_res_q[2];
	assign result.ripper_found     = found_q[3];
	assign result.ripper_offset    = off_res_q[3];
	assign result.converter_found  = found_q[4];
	assign result.converter_offset = off_res_q[4];
	assign result.replay_rate      = rate_q;
	assign result.rate_source      = src_q;

`ifndef SYNTHESIS
	a_ready_only_on_result_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> (vld_s1 && last_s1 && out_vld_q && !result.ready))
		else $error("byte channel stalled without a pending result");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> result.valid)
		else $error("last byte did not load a result");

	a_state_cleared_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (pos_q == '0 && long_seen_q == '0 && short_seen_q == '0))
		else $error("scan state not cleared after a result");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.header_valid) |->
		(found_q == '0 && rate_q == '0 && src_q == '0))
		else $error("fields not zero on invalid header");
`endif

endmodule

[dv/music_header_tag_scanner_top_test.sv]
`timescale 1ns / 100ps
// Testbench for music_header_tag_scanner_top: streams header files one byte per request
// and checks every summary against a behavioral scan model kept in this module.
// Depends on mhts_pkg, mhts_byte_if, mhts_result_if and the scanner RTL.
module music_header_tag_scanner_top_test;
	import mhts_pkg::*;

	localparam int SCAN_WINDOW  = DEFAULT_SCAN_WINDOW;
	localparam int IDLE_PCT     = 27;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_BYTES = 720;
	localparam int DRAIN_CYCLES = 10;

	// long tag indexes after SNDH
	localparam int LT_TITL = 1;
	localparam int LT_COMM = 2;
	localparam int LT_RIPP = 3;
	localparam int LT_CONV = 4;

	// short tag indexes, also the rate source codes
	localparam int ST_TC   = 0;
	localparam int ST_TA   = 1;
	localparam int ST_TB   = 2;
	localparam int ST_TD   = 3;
	localparam int ST_VBNG = 4;

	typedef struct packed {
		logic             header_valid;
		logic             title_found;
		logic [OFF_W-1:0] title_offset;
		logic             composer_found;
		logic [OFF_W-1:0] composer_offset;
		logic             ripper_found;
		logic [OFF_W-1:0] ripper_offset;
		logic             converter_found;
		logic [OFF_W-1:0] converter_offset;
		logic [ACC_W-1:0] replay_rate;
		logic [SRC_W-1:0] rate_source;
	} scan_summary_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mhts_byte_if   bytes_ch();
	mhts_result_if result_ch();

	music_header_tag_scanner_top #(.SCAN_WINDOW(SCAN_WINDOW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// scan model state
	logic [23:0]          hist;
	logic [POS_W-1:0]     pos;
	logic [NUM_LONG-1:0]  long_seen;
	logic [OFF_W-1:0]     long_off [1:NUM_LONG-1];
	logic [NUM_SHORT-1:0] short_seen;
	logic [NUM_SHORT-1:0] running;
	logic [ACC_W-1:0]     acc [NUM_SHORT];

	scan_summary_t expected_summaries[$];
	logic [7:0]    file_bytes[$];

	bit steady_flow    = 1'b0;
	int bytes_sent     = 0;
	int summaries_seen = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	function automatic void clear_scan();
		hist       = '0;
		pos        = '0;
		long_seen  = '0;
		short_seen = '0;
		running    = '0;
		for (int k = 1; k < NUM_LONG; k++) long_off[k] = '0;
		for (int k = 0; k < NUM_SHORT; k++) acc[k] = '0;
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input logic last);
		logic [31:0]   w4;
		logic [15:0]   w2;
		scan_summary_t s;
		w4 = {hist, b};
		w2 = {hist[7:0], b};
		// accumulators started by earlier bytes
		for (int k = 0; k < NUM_SHORT; k++) begin
			if (running[k]) begin
				if (b == 8'h00)
					running[k] = 1'b0;
				else
					acc[k] = acc[k] * 16'd10 + ACC_W'(b) - ACC_W'(DIGIT_BASE);
			end
		end
		if (pos >= 3 && pos - 3 < SCAN_WINDOW) begin
			for (int k = 0; k < NUM_LONG; k++) begin
				if (!long_seen[k] && w4 == LONG_TAGS[k]) begin
					long_seen[k] = 1'b1;
					if (k != LT_SNDH) long_off[k] = OFF_W'(pos + 1);
				end
			end
		end
		// a tag's own second byte never reaches its accumulator
		if (pos >= 1 && pos - 1 < SCAN_WINDOW) begin
			for (int k = 0; k < NUM_SHORT; k++) begin
				if (!short_seen[k] && w2 == SHORT_TAGS[k]) begin
					short_seen[k] = 1'b1;
					running[k]    = 1'b1;
				end
			end
		end
		hist = w4[23:0];
		if (pos != POS_MAX) pos++;
		if (last) begin
			s = '0;
			if (long_seen[LT_SNDH]) begin
				s.header_valid     = 1'b1;
				s.title_found      = long_seen[LT_TITL];
				s.title_offset     = long_off[LT_TITL];
				s.composer_found   = long_seen[LT_COMM];
				s.composer_offset  = long_off[LT_COMM];
				s.ripper_found     = long_seen[LT_RIPP];
				s.ripper_offset    = long_off[LT_RIPP];
				s.converter_found  = long_seen[LT_CONV];
				s.converter_offset = long_off[LT_CONV];
				s.replay_rate      = DEFAULT_RATE;
				s.rate_source      = SRC_DEFAULT;
				// walk down so the highest-priority tag wins
				for (int k = NUM_SHORT - 1; k >= 0; k--) begin
					if (short_seen[k]) begin
						s.replay_rate = acc[k];
						s.rate_source = SRC_W'(k);
					end
				end
			end
			expected_summaries.push_back(s);
			clear_scan();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("summary %0d: %s got %0d, expected %0d", summaries_seen, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	task automatic check_summary();
		scan_summary_t want;
		if (expected_summaries.size() == 0) begin
			report_mismatch("result with nothing pending", 16'd1, 16'd0);
		end else begin
			want = expected_summaries.pop_front();
			check_field("header_valid", result_ch.header_valid, want.header_valid);
			check_field("title_found", result_ch.title_found, want.title_found);
			check_field("title_offset", result_ch.title_offset, want.title_offset);
			check_field("composer_found", result_ch.composer_found, want.composer_found);
			check_field("composer_offset", result_ch.composer_offset,
				want.composer_offset);
			check_field("ripper_found", result_ch.ripper_found, want.ripper_found);
			check_field("ripper_offset", result_ch.ripper_offset, want.ripper_offset);
			check_field("converter_found", result_ch.converter_found,
				want.converter_found);
			check_field("converter_offset", result_ch.converter_offset,
				want.converter_offset);
			check_field("replay_rate", result_ch.replay_rate, want.replay_rate);
			check_field("rate_source", result_ch.rate_source, want.rate_source);
		end
		summaries_seen++;
	endtask

	// result side: check on accept, stall at random
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) check_summary();
		result_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (bytes_ch.valid && bytes_ch.ready)
			|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("music_header_tag_scanner_top_test: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid     <= 1'b1;
		bytes_ch.file_byte <= b;
		bytes_ch.last_byte <= last;
		@(posedge clk);
		while (!bytes_ch.ready) @(posedge clk);
		scan_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_file();
		foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	task automatic append_long(input int k, input int keep = 4);
		for (int i = 0; i < keep; i++) file_bytes.push_back(LONG_TAGS[k][31-8*i -: 8]);
	endtask

	task automatic append_short(input int k);
		file_bytes.push_back(SHORT_TAGS[k][15:8]);
		file_bytes.push_back(SHORT_TAGS[k][7:0]);
	endtask

	// short tag, some digits (now and then any byte), usually a terminator
	task automatic append_number(input int k);
		append_short(k);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(9) < 9)
				file_bytes.push_back(DIGIT_BASE + 8'($urandom_range(0, 9)));
			else
				file_bytes.push_back(8'($urandom));
		end
		if ($urandom_range(99) < 70) file_bytes.push_back(8'h00);
	endtask

	task automatic fill_filler(input int n);
		file_bytes.delete();
		// lowercase letters match no tag
		repeat (n) file_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
	endtask

	task automatic put_long(input int at, input int k);
		for (int i = 0; i < 4; i++) file_bytes[at+i] = LONG_TAGS[k][31-8*i -: 8];
	endtask

	task automatic put_short(input int at, input int k);
		file_bytes[at]   = SHORT_TAGS[k][15:8];
		file_bytes[at+1] = SHORT_TAGS[k][7:0];
	endtask

	task automatic test_invalid_header();
		file_bytes.delete();
		append_long(LT_TITL);
		file_bytes.push_back(8'h00);
		send_file();
	endtask

	// CONV completes on the last byte itself
	task automatic test_all_metadata_tags();
		file_bytes.delete();
		for (int k = 0; k < NUM_LONG; k++) append_long(k);
		send_file();
	endtask

	task automatic test_unterminated_rate();
		file_bytes.delete();
		append_long(LT_SNDH);
		append_short(ST_VBNG);
		file_bytes.push_back(8'hFF);
		send_file();
	endtask

	// tags straddling the end of the scan window; TD runs across the tags after it
	task automatic test_window_edge();
		fill_filler(SCAN_WINDOW + 12);
		put_long(0, LT_SNDH);
		put_short(SCAN_WINDOW - 3, ST_TD);
		put_long(SCAN_WINDOW - 1, LT_TITL);
		put_long(SCAN_WINDOW + 3, LT_COMM);
		put_short(SCAN_WINDOW + 7, ST_TC);
		file_bytes[SCAN_WINDOW + 9]  = DIGIT_BASE + 8'd5;
		file_bytes[SCAN_WINDOW + 10] = 8'h00;
		send_file();

		// the next file must start clean; TA outranks TB
		file_bytes.delete();
		append_long(LT_SNDH);
		append_short(ST_TB);
		file_bytes.push_back(DIGIT_BASE + 8'd7);
		file_bytes.push_back(8'h00);
		append_short(ST_TA);
		file_bytes.push_back(DIGIT_BASE + 8'd3);
		send_file();
	endtask

	task automatic build_random_file();
		int pieces;
		int sndh_at;
		file_bytes.delete();
		pieces  = $urandom_range(1, 10);
		sndh_at = ($urandom_range(99) < 85) ? $urandom_range(0, pieces - 1) : -1;
		for (int i = 0; i < pieces; i++) begin
			if (i == sndh_at) append_long(LT_SNDH);
			case ($urandom_range(0, 9))
				0, 1: append_long($urandom_range(0, NUM_LONG - 1));
				2, 3, 4: append_number($urandom_range(0, NUM_SHORT - 1));
				5: begin
					// truncated long tag followed by noise
					append_long($urandom_range(0, NUM_LONG - 1), $urandom_range(1, 3));
					file_bytes.push_back(8'($urandom));
				end
				6: file_bytes.push_back(SHORT_TAGS[$urandom_range(0, NUM_SHORT - 1)][15:8]);
				7: file_bytes.push_back(8'h00);
				default: repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom));
			endcase
		end
	endtask

	task automatic test_random_files();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			steady_flow = (bytes_sent - start >= 250) && (bytes_sent - start < 500);
			build_random_file();
			send_file();
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		bytes_ch.valid     = 1'b0;
		bytes_ch.file_byte = 8'h00;
		bytes_ch.last_byte = 1'b0;
		result_ch.ready    = 1'b0;
		clear_scan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_invalid_header();
		test_all_metadata_tags();
		test_unterminated_rate();
		test_window_edge();
		test_random_files();
		bytes_ch.valid <= 1'b0;

		while (expected_summaries.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("music_header_tag_scanner_top_test: done, clean");
		else
			$display("music_header_tag_scanner_top_test: done, errors");
		$finish;
	end

endmodule

[files.f]
hdl/mhts_pkg.sv
hdl/mhts_byte_if.sv
hdl/mhts_result_if.sv
hdl/mhts_tag_match.sv
hdl/mhts_dec_acc.sv
hdl/music_header_tag_scanner_top.sv
dv/music_header_tag_scanner_top_test.sv
